[rtl/core/bbma_pkg.sv]
// Shared types and constants for the bounded byte memory.
// Request, response and internal command structs; no dependencies.
package bbma_pkg;

	// request type codes
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// access width codes; the unused code acts as a word
	localparam logic [1:0] WIDTH_BYTE = 2'd0;
	localparam logic [1:0] WIDTH_HALF = 2'd1;
	localparam logic [1:0] WIDTH_WORD = 2'd2;

	localparam int unsigned LANES = 4;

	localparam logic [7:0]  FILL_BYTE    = 8'hA5;
	localparam logic [16:0] MEM_SIZE_RST = 17'h10000;
	localparam logic [31:0] SIZE_ROUND   = 32'd15;
	localparam logic [31:0] SIZE_MASK    = 32'hFFFF_FFF0;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  access_width;
		logic        sign_extend;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        out_of_range;
	} rsp_t;

	// classified access, indexed by byte lane (address mod 4)
	typedef struct packed {
		logic                   is_write;
		logic [1:0]             access_width;
		logic                   sign_extend;
		logic [31:0]            address;
		logic [LANES-1:0]       lane_en;
		logic [LANES-1:0][7:0]  lane_wdata;
		logic                   bad;
	} cmd_t;

endpackage

[rtl/core/bounded_byte_memory_access.sv]
// Bounded byte memory, top level: front end, command queue, back end.
// Depends on bbma_pkg, bbma_front, bbma_queue and bbma_back.
//
// Little-endian byte-addressable memory with a programmable bound. Each
// request is a read or write of 1, 2 or 4 bytes (width code 3 acts as a
// word) at any byte address; byte k lives at address+k, wrapping at 2^32.
// Every byte is checked on its own against the usable size, which is the
// mem_size register rounded up to a multiple of 16 and capped at MEM_BYTES.
// Illegal bytes read as zero and drop on write; out_of_range flags any
// illegal byte. Reads optionally sign-extend; writes return read_data 0.
// The store sits in four single-port byte-lane banks, so any access, even
// an unaligned one, touches each bank at most once: the block sustains one
// transfer per cycle when the response side is not stalled; results come
// through a read stage and response register. A two-entry queue separates the
// bounds-check front end from the bank back end. After reset the banks are
// filled with 0xA5 one row per cycle, ceil(MEM_BYTES/4) rows (16384 at
// the default size), while req_ready stays low; size writes are taken at
// any time (cfg_ready is always high) but must only be made while idle.
// A size change moves the bound only; stored contents are kept.
module bounded_byte_memory_access #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [16:0]     cfg_mem_size,
	input  logic            req_valid,
	output logic            req_ready,
	input  bbma_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bbma_pkg::rsp_t  rsp
);

	logic           clearing;
	logic           enq_valid;
	logic           enq_ready;
	bbma_pkg::cmd_t enq_cmd;
	logic           deq_valid;
	logic           deq_ready;
	bbma_pkg::cmd_t deq_cmd;

	assign cfg_ready = 1'b1;

	// bounds check and lane steering
	bbma_front #(
		.MEM_BYTES (MEM_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_mem_size (cfg_mem_size),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.clearing     (clearing),
		.enq_valid    (enq_valid),
		.enq_ready    (enq_ready),
		.enq_cmd      (enq_cmd)
	);

	// decouples request acceptance from bank stalls
	bbma_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (enq_valid),
		.in_ready  (enq_ready),
		.in_cmd    (enq_cmd),
		.out_valid (deq_valid),
		.out_ready (deq_ready),
		.out_cmd   (deq_cmd)
	);

	// banks, read assembly and response register
	bbma_back #(
		.MEM_BYTES (MEM_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_cmd   (deq_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.clearing  (clearing)
	);

endmodule

[rtl/core/bbma_front.sv]
// Front end: size register, per-byte bounds check, lane steering.
// Depends on bbma_pkg.
module bbma_front #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [16:0]     cfg_mem_size,
	input  logic            req_valid,
	output logic            req_ready,
	input  bbma_pkg::req_t  req,
	input  logic            clearing,
	output logic            enq_valid,
	input  logic            enq_ready,
	output bbma_pkg::cmd_t  enq_cmd
);

	localparam int unsigned LIM_W   = $clog2(MEM_BYTES + 1);
	localparam logic [31:0] CAP     = 32'(MEM_BYTES);
	localparam logic [31:0] RST_SZ  = 32'(bbma_pkg::MEM_SIZE_RST);
	localparam logic [31:0] RST_LIM = (CAP < RST_SZ) ? CAP : RST_SZ;

	logic [LIM_W-1:0] limit_q;
	logic [31:0]      rnd;
	logic [31:0]      lim_nxt;

	always_comb begin
		rnd     = (32'(cfg_mem_size) + bbma_pkg::SIZE_ROUND) & bbma_pkg::SIZE_MASK;
		lim_nxt = (rnd > CAP) ? CAP : rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(RST_LIM);
		end else if (cfg_valid) begin
			limit_q <= LIM_W'(lim_nxt);
		end
	end

	logic [bbma_pkg::LANES-1:0]      in_acc;
	logic [bbma_pkg::LANES-1:0]      lane_en;
	logic [bbma_pkg::LANES-1:0][7:0] lane_wdata;
	logic [31:0]                     byte_addr;
	logic [1:0]                      lane;
	logic                            ok;
	logic                            bad;

	always_comb begin
		unique case (req.access_width)
			bbma_pkg::WIDTH_BYTE: in_acc = 4'b0001;
			bbma_pkg::WIDTH_HALF: in_acc = 4'b0011;
			default:              in_acc = 4'b1111;
		endcase
		lane_en    = '0;
		lane_wdata = '0;
		bad        = 1'b0;
		byte_addr  = '0;
		lane       = '0;
		ok         = 1'b0;
		for (int k = 0; k < bbma_pkg::LANES; k++) begin
			byte_addr = req.address + 32'(k);
			ok        = byte_addr < 32'(limit_q);
			lane      = 2'(req.address[1:0] + 2'(k));
			if (in_acc[k]) begin
				if (ok) begin
					lane_en[lane] = 1'b1;
				end else begin
					bad = 1'b1;
				end
			end
			lane_wdata[lane] = req.write_data[8*k +: 8];
		end
	end

	always_comb begin
		enq_cmd.is_write     = (req.req_type == bbma_pkg::REQ_WRITE);
		enq_cmd.access_width = req.access_width;
		enq_cmd.sign_extend  = req.sign_extend;
		enq_cmd.address      = req.address;
		enq_cmd.lane_en      = lane_en;
		enq_cmd.lane_wdata   = lane_wdata;
		enq_cmd.bad          = bad;
	end

	// no transfer while the store is being filled after reset
	assign enq_valid = req_valid && !clearing;
	assign req_ready = enq_ready && !clearing;

endmodule

[rtl/core/bbma_queue.sv]
// Two-entry command queue between front and back end.
// Depends on bbma_pkg.
module bbma_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bbma_pkg::cmd_t  in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output bbma_pkg::cmd_t  out_cmd
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bbma_pkg::cmd_t   ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_cmd   = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[rtl/core/bbma_back.sv]
// Back end: four byte-lane banks, fill pass, read assembly, output register.
// Depends on bbma_pkg.
module bbma_back #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            deq_valid,
	output logic            deq_ready,
	input  bbma_pkg::cmd_t  deq_cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bbma_pkg::rsp_t  rsp,
	output logic            clearing
);

	localparam int unsigned DEPTH = (MEM_BYTES + 3) / 4;
	localparam int unsigned ROW_W = $clog2(DEPTH);

	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;

	logic             pop;
	logic             mv_s1;
	logic             vld_s1;
	logic             is_write_s1;
	logic [1:0]       width_s1;
	logic             sx_s1;
	logic [1:0]       lo_s1;
	logic [3:0]       lane_en_s1;
	logic             bad_s1;
	logic [7:0]       rd_s1 [bbma_pkg::LANES];

	bbma_pkg::rsp_t   rsp_q;
	logic             rsp_vld_q;

	assign clearing  = clr_busy_q;
	assign mv_s1     = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign deq_ready = !clr_busy_q && (!vld_s1 || mv_s1);
	assign pop       = deq_valid && deq_ready;

	// fill pass: one row of every lane per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == ROW_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_row_q <= ROW_W'(clr_row_q + 1'b1);
		end
	end

	for (genvar L = 0; L < bbma_pkg::LANES; L++) begin : gen_lane
		logic [7:0]       mem_q [DEPTH];
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] addr;
		logic             carry;
		logic             we;
		logic [7:0]       wd;

		// lanes below the start lane belong to the next row
		assign carry = (2'(L) < deq_cmd.address[1:0]);
		assign row   = ROW_W'(deq_cmd.address[ROW_W+1:2]) + ROW_W'(carry);
		assign addr  = clr_busy_q ? clr_row_q : row;
		assign we    = clr_busy_q || (pop && deq_cmd.is_write && deq_cmd.lane_en[L]);
		assign wd    = clr_busy_q ? bbma_pkg::FILL_BYTE : deq_cmd.lane_wdata[L];

		always_ff @(posedge clk) begin
			if (we) begin
				mem_q[addr] <= wd;
			end
			if (pop && !deq_cmd.is_write) begin
				rd_s1[L] <= mem_q[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pop) begin
			vld_s1 <= 1'b1;
		end else if (mv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_write_s1 <= deq_cmd.is_write;
			width_s1    <= deq_cmd.access_width;
			sx_s1       <= deq_cmd.sign_extend;
			lo_s1       <= deq_cmd.address[1:0];
			lane_en_s1  <= deq_cmd.lane_en;
			bad_s1      <= deq_cmd.bad;
		end
	end

	logic [31:0] lanes;
	logic [31:0] value;

	always_comb begin
		lanes = '0;
		for (int L = 0; L < bbma_pkg::LANES; L++) begin
			lanes[8*L +: 8] = lane_en_s1[L] ? rd_s1[L] : 8'h00;
		end
		unique case (lo_s1)
			2'd0: value = lanes;
			2'd1: value = {lanes[7:0],  lanes[31:8]};
			2'd2: value = {lanes[15:0], lanes[31:16]};
			2'd3: value = {lanes[23:0], lanes[31:24]};
		endcase
		if (is_write_s1) begin
			value = '0;
		end else if (sx_s1) begin
			if (width_s1 == bbma_pkg::WIDTH_BYTE && value[7]) begin
				value[31:8] = '1;
			end else if (width_s1 == bbma_pkg::WIDTH_HALF && value[15]) begin
				value[31:16] = '1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (mv_s1) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			rsp_q.read_data    <= value;
			rsp_q.out_of_range <= bad_s1;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	a_no_pop_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && clr_busy_q))
		else $error("command taken during fill pass");

	a_lane_count: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && width_s1 == bbma_pkg::WIDTH_BYTE |-> $countones(lane_en_s1) <= 1)
		else $error("byte access enables more than one lane");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 && is_write_s1 |=> rsp_q.read_data == 32'd0)
		else $error("write returned nonzero data");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !mv_s1 |=> vld_s1 && $stable(lo_s1) && $stable(lane_en_s1))
		else $error("stalled access lost its state");

endmodule

[tb/bounded_byte_memory_access_tb.sv]
// Self-checking testbench for bounded_byte_memory_access: directed and random accesses.
// Depends on bbma_pkg and the RTL. An in-bench scoreboard predicts every response.
module bounded_byte_memory_access_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbma_pkg::*;

	localparam int unsigned MEM_BYTES       = 65536;
	// the post-reset fill covers MEM_BYTES/4 rows, the rest is a wide margin
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned ITEMS_PER_PHASE = 180;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned MAX_REPORTS     = 10;
	// the fourth width code has no package name; the block treats it as a word
	localparam logic [1:0]  WIDTH_SPARE     = 2'd3;

	// Shadow copy of the byte store and size register. Every accepted request
	// is applied here in order and its response is queued for comparison.
	class byte_memory_scoreboard;
		logic [7:0]  mem_bytes [MEM_BYTES];
		logic [16:0] size_reg;
		rsp_t        expected_q [$];
		int unsigned mismatches;

		function new();
			foreach (mem_bytes[i]) mem_bytes[i] = FILL_BYTE;
			size_reg   = MEM_SIZE_RST;
			mismatches = 0;
		endfunction

		// size rounded up to 16 bytes, saturating at the store depth
		function logic [31:0] usable_bytes();
			logic [31:0] s;
			s = (32'(size_reg) + SIZE_ROUND) & SIZE_MASK;
			if (s > MEM_BYTES) s = MEM_BYTES;
			return s;
		endfunction

		function void set_size(logic [16:0] v);
			size_reg = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void note_request(req_t r);
			logic [31:0] bound;
			logic [31:0] a;
			logic [31:0] value;
			logic        bad;
			int unsigned nbytes;
			rsp_t        want;
			bound  = usable_bytes();
			value  = '0;
			bad    = 1'b0;
			nbytes = (r.access_width == WIDTH_BYTE) ? 1 :
			         (r.access_width == WIDTH_HALF) ? 2 : 4;
			// each byte is bounds checked on its own; address wraps at 2^32
			for (int k = 0; k < nbytes; k++) begin
				a = r.address + 32'(k);
				if (a >= bound)
					bad = 1'b1;
				else if (r.req_type == REQ_WRITE)
					mem_bytes[a[15:0]] = r.write_data[8*k +: 8];
				else
					value[8*k +: 8] = mem_bytes[a[15:0]];
			end
			if (r.req_type == REQ_WRITE) begin
				value = '0;
			end else if (r.sign_extend) begin
				if (nbytes == 1 && value[7])       value[31:8]  = '1;
				else if (nbytes == 2 && value[15]) value[31:16] = '1;
			end
			want.read_data    = value;
			want.out_of_range = bad;
			expected_q.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected response read_data=%h out_of_range=%b",
					got.read_data, got.out_of_range));
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data || got.out_of_range !== want.out_of_range)
				flag($sformatf("read_data exp %h got %h, out_of_range exp %b got %b",
					want.read_data, got.read_data, want.out_of_range, got.out_of_range));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_mem_size;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;

	byte_memory_scoreboard sb = new();

	// Knobs shared between the request and response processes.
	int unsigned hold_requests = 0;  // bumped to ask the response side for a long hold-off
	int unsigned rsp_stall_pct = 30; // chance of starting a response stall
	bit          no_idle       = 1'b0; // back-to-back stretch: no gaps on either side
	int unsigned cycle_count   = 0;

	bounded_byte_memory_access #(
		.MEM_BYTES(MEM_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_mem_size(cfg_mem_size),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a response never shows up or ready sticks low.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Response side: sample the transfer at the rising edge, pick the next
	// ready value at the falling edge. A hold-off request from the stimulus
	// side forces a long stall counted here, independent of the sender.
	initial begin : response_side
		int unsigned stall_left;
		int unsigned holds_done;
		stall_left = 0;
		holds_done = 0;
		rsp_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready) sb.check_response(rsp);
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !no_idle && $urandom_range(99) < rsp_stall_pct) begin
				// mostly short stalls, now and then a long one
				stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
				                                      : $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t mk_req(logic kind, logic [1:0] width, logic sx,
	                                logic [31:0] addr, logic [31:0] data);
		req_t r;
		r.req_type     = kind;
		r.access_width = width;
		r.sign_extend  = sx;
		r.address      = addr;
		r.write_data   = data;
		return r;
	endfunction

	// Random access. Addresses cluster low (so reads hit earlier writes), around
	// the current bound, and just below 2^32 for the wrap, plus a few anywhere.
	function automatic req_t random_request();
		req_t        r;
		logic [31:0] bound;
		int unsigned pick;
		bound          = sb.usable_bytes();
		pick           = $urandom_range(99);
		r.req_type     = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_READ;
		r.access_width = 2'($urandom_range(3));
		r.sign_extend  = 1'($urandom_range(1));
		r.write_data   = $urandom();
		if (pick < 40)      r.address = $urandom_range(0, 255);
		else if (pick < 70) r.address = bound - 32'd8 + 32'($urandom_range(0, 16));
		else if (pick < 80) r.address = 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
		else if (pick < 90) r.address = $urandom_range(0, MEM_BYTES + 15);
		else                r.address = $urandom();
		return r;
	endfunction

	// Present one request from a falling edge until the transfer, then leave a
	// random gap. With no gap, valid stays high for the next call.
	task automatic send_request(req_t r);
		int unsigned gap;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		@(negedge clk);
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop offering requests and wait until every response is back, then let
	// the pipeline go quiet.
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Size writes only while the block is idle.
	task automatic write_size(logic [16:0] v);
		settle();
		cfg_mem_size <= v;
		cfg_valid    <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_size(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [16:0] sizes [10];
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_mem_size = '0;
		req_valid    = 1'b0;
		req          = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at full size. The first send also waits out the fill.
		write_size(MEM_SIZE_RST);
		send_request(mk_req(REQ_WRITE, WIDTH_WORD, 1'b0, 32'h0, 32'h80FF_7F01));
		send_request(mk_req(REQ_READ,  WIDTH_BYTE, 1'b0, 32'h0, 32'h0));
		send_request(mk_req(REQ_READ,  WIDTH_BYTE, 1'b1, 32'h3, 32'h0)); // negative byte
		send_request(mk_req(REQ_READ,  WIDTH_BYTE, 1'b1, 32'h1, 32'h0)); // positive byte
		send_request(mk_req(REQ_READ,  WIDTH_HALF, 1'b1, 32'h2, 32'h0)); // negative half
		send_request(mk_req(REQ_READ,  WIDTH_HALF, 1'b0, 32'h2, 32'h0));
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b1, 32'h0, 32'h0)); // sx has no effect
		send_request(mk_req(REQ_READ,  WIDTH_SPARE, 1'b1, 32'h1, 32'h0)); // acts as a word
		// sign extend on a write is ignored
		send_request(mk_req(REQ_WRITE, WIDTH_BYTE, 1'b1, 32'h5, 32'hFFFF_FFFF));
		send_request(mk_req(REQ_WRITE, WIDTH_HALF, 1'b0, 32'h7, 32'h1234_5678));
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b0, 32'h5, 32'h0));
		// wrap past 2^32: top bytes illegal, the rest land at address 0 and up
		send_request(mk_req(REQ_WRITE, WIDTH_WORD, 1'b0, 32'hFFFF_FFFE, 32'hDEAD_BEEF));
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b0, 32'hFFFF_FFFF, 32'h0));
		send_request(mk_req(REQ_READ,  WIDTH_HALF, 1'b1, 32'hFFFF_FFFF, 32'h0));
		// straddling the top of the store
		send_request(mk_req(REQ_WRITE, WIDTH_WORD, 1'b0, 32'd65534, 32'hCAFE_F00D));
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b0, 32'd65533, 32'h0));
		send_request(mk_req(REQ_READ,  WIDTH_BYTE, 1'b0, 32'd65536, 32'h0));
		send_request(mk_req(REQ_READ,  WIDTH_BYTE, 1'b1, 32'd65535, 32'h0));
		send_request(mk_req(REQ_WRITE, WIDTH_SPARE, 1'b0, 32'h100, 32'hFFFF_FFFF));
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b1, 32'h100, 32'h0));
		// zero size: every byte illegal, contents kept for later phases
		write_size(17'd0);
		send_request(mk_req(REQ_READ,  WIDTH_WORD, 1'b0, 32'h0, 32'h0));
		send_request(mk_req(REQ_WRITE, WIDTH_WORD, 1'b0, 32'h10, 32'h0BAD_F00D));

		// Random phases over a range of bounds, extremes included.
		sizes = '{17'h1FFFF, 17'd1, 17'd100, 17'd65535, 17'd0,
		          17'd65521, 17'd0, 17'd0, 17'd65520, 17'd65536};
		sizes[6] = 17'($urandom_range(0, 131071));
		sizes[7] = 17'($urandom_range(0, 4096));
		foreach (sizes[p]) begin
			write_size(sizes[p]);
			no_idle       = (p == 2);
			rsp_stall_pct = (p == 6) ? 70 : 30;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// long receiver hold-off under a gapless burst: the queue fills
				// and req_ready has to drop
				if (p == 3 && i == 40) begin
					hold_requests++;
					no_idle = 1'b1;
				end
				if (p == 3 && i == 80) no_idle = 1'b0;
				// sender goes quiet until everything has come back
				if (p == 5 && i == ITEMS_PER_PHASE / 2) settle();
				send_request(random_request());
			end
		end
		no_idle = 1'b0;
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
